/* sv/ras_pkg.sv */
// Package: shared types and constants for the rectangular assignment solver.
package ras_pkg;
  localparam int MaxDim = 16;
  localparam int CostW  = 16;
  localparam int WorkW  = 18;
  localparam int DualW  = 24;
  localparam int TotalW = 20;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNoCost  = 2'd1;
  localparam logic [1:0] StatusInfeas  = 2'd2;

  localparam logic [1:0] RegRows = 2'd0;
  localparam logic [1:0] RegCols = 2'd1;
  localparam logic [1:0] RegMax  = 2'd2;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // store incoming entry
    logic start;      // begin solve
    logic emit_take;  // a result has been transferred
  } ras_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic matrix_done; // entry being stored is the last one
    logic busy;        // solving
    logic out_valid;   // result waiting
  } ras_stat_t;
endpackage

/* sv/ras_if.sv */
// Interfaces: valid/ready channels for entries, results and configuration.
interface ras_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cost_value;
  logic               forbidden;
  modport source (output valid, cost_value, forbidden, input ready);
  modport sink   (input valid, cost_value, forbidden, output ready);
endinterface

interface ras_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         row_number;
  logic [4:0]         matched_column;
  logic signed [19:0] total_cost;
  logic [1:0]         status;
  logic               last;
  modport source (output valid, row_number, matched_column, total_cost, status, last,
                  input ready);
  modport sink   (input valid, row_number, matched_column, total_cost, status, last,
                  output ready);
endinterface

interface ras_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/ras_ctrl.sv */
// Controller: top-level sequencing of load, solve and result phases.
module ras_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output ras_pkg::ras_cmd_t   cmd,
  input  ras_pkg::ras_stat_t  stat
);
  import ras_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD  = 3'b001,
    S_SOLVE = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && stat.matrix_done) begin
          cmd.start = 1'b1;
          state_next = S_SOLVE;
        end
      end
      S_SOLVE: begin
        if (!stat.busy) state_next = S_EMIT;
      end
      S_EMIT: begin
        out_valid = stat.out_valid;
        cmd.emit_take = out_ready && stat.out_valid;
        if (!stat.out_valid) state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end
endmodule

/* sv/ras_dp.sv */
// Datapath: cost memories, duals, matching and the sequenced Hungarian search.
module ras_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  ras_pkg::ras_cmd_t         cmd,
  output ras_pkg::ras_stat_t        stat,
  input  logic signed [15:0]        cost_value,
  input  logic                      forbidden,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [4:0]                cfg_data,
  output logic [3:0]                row_number,
  output logic [4:0]                matched_column,
  output logic signed [19:0]        total_cost,
  output logic [1:0]                status,
  output logic                      last
);
  import ras_pkg::*;

  localparam int DW    = $clog2(MaxDim);
  localparam int DEPTH = MaxDim * MaxDim;
  localparam int AW    = 2 * DW;

  // Phase codes of the solve sequencer.
  typedef enum logic [10:0] {
    P_IDLE   = 11'b00000000001,
    P_SCAN   = 11'b00000000010,
    P_MAXMIN = 11'b00000000100,
    P_COLMIN = 11'b00000001000,
    P_ROOT   = 11'b00000010000,
    P_TIGHT  = 11'b00000100000,
    P_AUG    = 11'b00001000000,
    P_SLACK  = 11'b00010000000,
    P_UPD    = 11'b00100000000,
    P_TOTAL  = 11'b01000000000,
    P_OUT    = 11'b10000000000
  } phase_t;

  logic [4:0] rows_reg, cols_reg;
  logic       max_reg;
  logic [DW:0] n0, m0, n, m;
  logic        transposed;
  logic        cfg_hit;

  // Only a write to an existing register restarts the load.
  assign cfg_hit = cfg_we &&
                   (cfg_index == RegRows || cfg_index == RegCols || cfg_index == RegMax);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_reg <= 5'd16; cols_reg <= 5'd16; max_reg <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegRows: rows_reg <= cfg_data;
        RegCols: cols_reg <= cfg_data;
        RegMax:  max_reg  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  function automatic logic [DW:0] clampd(input logic [4:0] v);
    if (v == 5'd0) return (DW+1)'(1);
    if (32'(v) > MaxDim) return (DW+1)'(MaxDim);
    return (DW+1)'(v);
  endfunction

  assign n0 = clampd(rows_reg);
  assign m0 = clampd(cols_reg);
  assign transposed = n0 > m0;
  assign n = transposed ? m0 : n0;
  assign m = transposed ? n0 : m0;

  // Original cost memory (value + forbid), row-major by original indices.
  logic [CostW:0] orig_mem [DEPTH];
  // Working cost memory indexed by working row/col.
  logic [WorkW:0] work_mem [DEPTH];

  logic [DW:0] ld_r, ld_c;
  assign stat.matrix_done = (ld_r == n0 - 1'b1) && (ld_c == m0 - 1'b1);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      ld_r <= '0; ld_c <= '0;
    end else if (cmd.load) begin
      if (ld_c >= m0 - 1'b1) begin
        ld_c <= '0;
        ld_r <= (ld_r >= n0 - 1'b1) ? '0 : ld_r + 1'b1;
      end else ld_c <= ld_c + 1'b1;
    end
  end

  // Sequencer state.
  phase_t      ph;
  logic [DW:0] ri, cj, root;
  logic signed [DualW-1:0] rdual [MaxDim];
  logic signed [DualW-1:0] cdual [MaxDim];
  logic [DW:0] rpart [MaxDim];
  logic [DW:0] cpart [MaxDim];
  logic [DW:0] cpar  [MaxDim];
  logic [MaxDim-1:0] rreach, creach;
  logic signed [CostW-1:0] largest;
  logic found, have, progressed;
  logic signed [DualW-1:0] acc;
  logic signed [TotalW-1:0] total;
  logic [1:0] stat_code;
  logic [DW:0] aug_c;

  // Registered memory read.
  logic [AW-1:0] rd_addr, wr_addr;
  logic [CostW:0] orig_q;
  logic [WorkW:0] work_q;
  logic [WorkW:0] work_wd;
  logic           work_we;
  logic           rd_ok;
  logic [DW:0]    q_i, q_j;

  always_ff @(posedge clk) begin
    if (cmd.load) orig_mem[{ld_r[DW-1:0], ld_c[DW-1:0]}] <= {forbidden, cost_value};
    orig_q <= orig_mem[rd_addr];
    if (work_we) work_mem[wr_addr] <= work_wd;
    work_q <= work_mem[rd_addr];
  end

  // Scan address: working (ri, cj) maps to original address.
  function automatic logic [AW-1:0] oaddr(input logic [DW:0] i, input logic [DW:0] j,
                                          input logic t);
    return t ? {j[DW-1:0], i[DW-1:0]} : {i[DW-1:0], j[DW-1:0]};
  endfunction

  logic step_last_col;
  assign step_last_col = (cj == m - 1'b1);

  logic signed [DualW-1:0] slk;
  logic signed [DualW-1:0] wcost;
  assign wcost = DualW'($signed(work_q[WorkW-1:0]));
  assign slk = wcost - rdual[q_i[DW-1:0]] - cdual[q_j[DW-1:0]];
  logic wforb;
  assign wforb = work_q[WorkW];

  logic signed [WorkW-1:0] wval;
  assign wval = max_reg && !orig_q[CostW]
              ? WorkW'($signed(largest)) - WorkW'($signed(orig_q[CostW-1:0]))
              : WorkW'($signed(orig_q[CostW-1:0]));

  logic [DW:0] out_idx;
  logic [DW:0] match_col;
  logic [MaxDim-1:0] cpart_valid;

  always_comb begin
    rd_addr = '0;
    priority case (ph)
      P_SCAN, P_MAXMIN, P_TOTAL: rd_addr = oaddr(ri, cj, transposed);
      default: rd_addr = {ri[DW-1:0], cj[DW-1:0]};
    endcase
    if (ph == P_TOTAL) rd_addr = oaddr(ri, rpart[ri[DW-1:0]], transposed);
  end

  assign work_we = (ph == P_MAXMIN) && rd_ok;
  assign wr_addr = {q_i[DW-1:0], q_j[DW-1:0]};
  assign work_wd = {orig_q[CostW], wval};

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= P_IDLE;
      rd_ok <= 1'b0;
      for (int k = 0; k < MaxDim; k++) begin
        rdual[k] <= '0; cdual[k] <= '0;
        rpart[k] <= '1; cpart[k] <= '1; cpar[k] <= '1;
      end
      rreach <= '0; creach <= '0;
      largest <= '0;
    end else begin
      q_i <= ri; q_j <= cj;
      unique case (ph)
        P_IDLE: begin
          rd_ok <= 1'b0;
          if (cmd.start) begin
            ph <= P_SCAN; ri <= '0; cj <= '0; found <= 1'b0;
          end
        end
        // Find largest allowed original cost.
        P_SCAN: begin
          rd_ok <= 1'b1;
          if (rd_ok && !orig_q[CostW] &&
              (!found || $signed(orig_q[CostW-1:0]) > largest)) begin
            largest <= orig_q[CostW-1:0]; found <= 1'b1;
          end
          if (step_last_col) begin
            cj <= '0;
            if (ri == n - 1'b1) begin ri <= n; end else ri <= ri + 1'b1;
          end else cj <= cj + 1'b1;
          if (ri == n) begin
            rd_ok <= 1'b0;
            ri <= '0; cj <= '0;
            if (!found && !(rd_ok && !orig_q[CostW])) begin
              stat_code <= StatusNoCost; ph <= P_OUT; out_idx <= '0;
            end else ph <= P_MAXMIN;
          end
        end
        // Write working costs.
        P_MAXMIN: begin
          rd_ok <= 1'b1;
          if (step_last_col) begin
            cj <= '0;
            ri <= (ri == n - 1'b1) ? n : ri + 1'b1;
          end else cj <= cj + 1'b1;
          if (ri == n) begin
            rd_ok <= 1'b0; ri <= '0; cj <= '0; have <= 1'b0; acc <= '0;
            ph <= P_COLMIN;
          end
        end
        // Column minima, column-major walk: cj outer, ri inner.
        P_COLMIN: begin
          rd_ok <= (cj != m);
          if (rd_ok && !wforb && (!have || wcost < acc)) begin
            acc <= wcost; have <= 1'b1;
          end
          if (rd_ok && q_i == n - 1'b1) begin
            cdual[q_j[DW-1:0]] <= (!wforb && (!have || wcost < acc)) ? wcost :
                                  (have ? acc : '0);
            have <= 1'b0; acc <= '0;
          end
          if (cj != m) begin
            if (ri == n - 1'b1) begin ri <= '0; cj <= cj + 1'b1; end
            else ri <= ri + 1'b1;
          end else if (!rd_ok) begin
            root <= '0; ph <= P_ROOT;
            for (int k = 0; k < MaxDim; k++) begin
              rdual[k] <= '0; rpart[k] <= '1; cpart[k] <= '1;
            end
          end
        end
        P_ROOT: begin
          rd_ok <= 1'b0;
          if (root == n) begin
            ph <= P_TOTAL; ri <= '0; total <= '0; rd_ok <= 1'b0;
          end else if (rpart[root[DW-1:0]] != '1) root <= root + 1'b1;
          else begin
            rreach <= '0; creach <= '0;
            rreach[root[DW-1:0]] <= 1'b1;
            for (int k = 0; k < MaxDim; k++) cpar[k] <= '1;
            ri <= '0; cj <= '0; progressed <= 1'b0;
            ph <= P_TIGHT;
          end
        end
        // Tight-edge search: one edge per cycle, row-major, reached rows only.
        // Reads are issued ahead through the registered port; a row's reach may change
        // mid-walk, so each edge is checked when its data returns.
        P_TIGHT: begin
          rd_ok <= 1'b0;
          if (rd_ok) begin
            if (rreach[q_i[DW-1:0]] && !creach[q_j[DW-1:0]] && !wforb && slk == 0) begin
              cpar[q_j[DW-1:0]] <= q_i;
              creach[q_j[DW-1:0]] <= 1'b1;
              progressed <= 1'b1;
              if (cpart[q_j[DW-1:0]] == '1) begin
                aug_c <= q_j; ph <= P_AUG;
              end else begin
                rreach[cpart[q_j[DW-1:0]][DW-1:0]] <= 1'b1;
              end
            end
          end
          if (!(rd_ok && rreach[q_i[DW-1:0]] && !creach[q_j[DW-1:0]] && !wforb &&
                slk == 0 && cpart[q_j[DW-1:0]] == '1)) begin
            if (ri == n) begin
              if (!rd_ok) begin
                ri <= '0; cj <= '0;
                if (progressed) progressed <= 1'b0;
                else begin have <= 1'b0; ph <= P_SLACK; end
              end
            end else begin
              rd_ok <= 1'b1;
              if (step_last_col) begin cj <= '0; ri <= ri + 1'b1; end
              else cj <= cj + 1'b1;
            end
          end
        end
        // Walk back along parents, flipping the matching.
        P_AUG: begin
          cpart[aug_c[DW-1:0]] <= cpar[aug_c[DW-1:0]];
          rpart[cpar[aug_c[DW-1:0]][DW-1:0]] <= aug_c;
          if (cpar[aug_c[DW-1:0]] == root || rpart[cpar[aug_c[DW-1:0]][DW-1:0]] == '1)
            ph <= P_ROOT;
          else aug_c <= rpart[cpar[aug_c[DW-1:0]][DW-1:0]];
        end
        // Least slack over reached rows and unreached columns.
        P_SLACK: begin
          rd_ok <= 1'b0;
          if (rd_ok && rreach[q_i[DW-1:0]] && !creach[q_j[DW-1:0]] && !wforb &&
              (!have || slk < acc)) begin
            acc <= slk; have <= 1'b1;
          end
          if (ri == n) begin
            if (!rd_ok) begin
              if (!have) begin stat_code <= StatusInfeas; out_idx <= '0; ph <= P_OUT; end
              else ph <= P_UPD;
            end
          end else begin
            rd_ok <= 1'b1;
            if (step_last_col) begin cj <= '0; ri <= ri + 1'b1; end
            else cj <= cj + 1'b1;
          end
        end
        P_UPD: begin
          for (int k = 0; k < MaxDim; k++) begin
            if (rreach[k]) rdual[k] <= rdual[k] + acc;
            if (creach[k]) cdual[k] <= cdual[k] - acc;
          end
          ri <= '0; cj <= '0; progressed <= 1'b0; ph <= P_TIGHT;
        end
        // Sum original costs of matched pairs.
        P_TOTAL: begin
          rd_ok <= 1'b0;
          if (rd_ok && rpart[q_i[DW-1:0]] != '1)
            total <= total + TotalW'($signed(orig_q[CostW-1:0]));
          if (ri != n) begin rd_ok <= 1'b1; ri <= ri + 1'b1; end
          else if (!rd_ok) begin stat_code <= StatusOk; out_idx <= '0; ph <= P_OUT; end
        end
        P_OUT: begin
          if (cmd.emit_take) begin
            if (stat_code != StatusOk || out_idx == n0 - 1'b1) ph <= P_IDLE;
            else out_idx <= out_idx + 1'b1;
          end
        end
        default: ph <= P_IDLE;
      endcase
    end
  end

  // Column index paired with the reported original row.
  always_comb begin
    match_col = '0;
    for (int k = 0; k < MaxDim; k++) cpart_valid[k] = 1'b0;
    if (transposed) begin
      // original row out_idx is working column out_idx
      if (cpart[out_idx[DW-1:0]] != '1) match_col = cpart[out_idx[DW-1:0]] + 1'b1;
    end else if (rpart[out_idx[DW-1:0]] != '1) match_col = rpart[out_idx[DW-1:0]] + 1'b1;
    cpart_valid[out_idx[DW-1:0]] = 1'b1;
  end

  logic okres;
  assign okres = stat_code == StatusOk;
  assign stat.busy = (ph != P_OUT) && (ph != P_IDLE) || cmd.start;
  assign stat.out_valid = (ph == P_OUT) && |cpart_valid;
  assign row_number = okres ? 4'(out_idx) : 4'd0;
  assign matched_column = okres ? 5'(match_col) : 5'd0;
  assign total_cost = okres ? total : '0;
  assign status = stat_code;
  assign last = !okres || out_idx == n0 - 1'b1;
endmodule

/* sv/rectangular_assignment_solver_top.sv */
// Top level: rectangular assignment solver with load, solve and result channels.
//
// Usage. Set rows_in_use (index 0), cols_in_use (index 1) and maximize
// (index 2) over the cfg channel while the block is idle; a write to any of them
// restarts the load at entry zero. Stream the rows*cols entries row-major over the
// entries channel, one transfer per cycle. On the final entry the solver
// runs and then presents one result per original row on the results channel,
// or a single result with status 1 (no allowed cost) or 2 (infeasible).
// The search walks the working matrix one edge per cycle through the
// registered cost memory port, in tight-edge passes and least-slack passes.
// Entries are not taken while solving or while results are pending.
// Reset (synchronous, rst high) returns the registers to 16, 16, minimise and
// empties the load counter. When the receiver stalls, hold the current result
// stable until it is transferred; nothing is dropped.
module rectangular_assignment_solver_top (
  input logic clk,
  input logic rst,
  ras_in_if.sink   entries,
  ras_out_if.source results,
  ras_cfg_if.sink  cfg
);
  import ras_pkg::*;

  ras_cmd_t  cmd;
  ras_stat_t stat;
  logic      cfg_we;

  // Configuration is always taken; the block is idle by contract.
  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  // Present a result only while the controller is in its result phase.
  ras_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(entries.valid), .in_ready(entries.ready),
    .out_valid(results.valid), .out_ready(results.ready),
    .cmd(cmd), .stat(stat)
  );

  ras_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cost_value(entries.cost_value), .forbidden(entries.forbidden),
    .cfg_we(cfg_we), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .row_number(results.row_number), .matched_column(results.matched_column),
    .total_cost(results.total_cost), .status(results.status), .last(results.last)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(entries.ready && results.valid))
    else $error("entry accepted while a result is pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |=> results.valid)
    else $error("result withdrawn under stall");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status != StatusOk |-> results.last)
    else $error("error result not marked last");
`endif
endmodule
